@@ rtl/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ID_W    = 16;
  localparam int PRIO_W  = 4;
  localparam int OCC_W   = 5;
  localparam int STAT_W  = 2;

  localparam logic [PRIO_W-1:0] PRIO_MIN = 4'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd10;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADPRIO = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

@@ rtl/spq_if.sv @@
// Request and result channel interfaces of the stable priority queue.
`timescale 1ns / 1ps

interface spq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [spq_pkg::ID_W-1:0]    job_id;
  logic [spq_pkg::PRIO_W-1:0]  job_priority;

  modport source (output valid, req_type, job_id, job_priority, input ready);
  modport sink   (input valid, req_type, job_id, job_priority, output ready);
endinterface

interface spq_out_if;
  logic                        valid;
  logic                        ready;
  logic [spq_pkg::STAT_W-1:0]  status;
  logic [spq_pkg::ID_W-1:0]    out_job_id;
  logic [spq_pkg::PRIO_W-1:0]  out_priority;
  logic [spq_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, status, out_job_id, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_job_id, out_priority, occupancy, output ready);
endinterface

@@ rtl/spq_cell.sv @@
// One slot of the sorted shift chain: holds an entry and shifts on insert or remove.
`timescale 1ns / 1ps

module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occ_self,
  input  logic                left_wants,
  input  spq_pkg::entry_t     left_entry,
  input  spq_pkg::entry_t     right_entry,
  output logic                wants,
  output spq_pkg::entry_t     entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // Empty slot or strictly worse priority: the new job belongs here or earlier
  assign wants = !occ_self || (entry_r.prio > ctrl.new_entry.prio);
  assign entry = entry_r;

  // Take the left neighbor's entry, the new job, or the right neighbor's entry
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.insert && wants) begin
      entry_nxt = left_wants ? left_entry : ctrl.new_entry;
    end else if (ctrl.remove) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ rtl/stable_priority_queue.sv @@
// A request's result is registered and shows in the cycle after it is accepted.
// Throughput: one request per cycle unless stalled; all chain cells update in parallel.
// A new request is taken while no result waits or the result is taken (in_chan.ready).
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
// Slot contents are not cleared; only slots below the job count are ever read.
`timescale 1ns / 1ps

module stable_priority_queue (
  input  logic         clk,
  input  logic         rst_n,
  spq_in_if.sink       in_chan,
  spq_out_if.source    out_chan
);

  localparam int D = spq_pkg::DEPTH;
  localparam int CW = spq_pkg::CNT_W;

  logic [CW-1:0]            count_r, count_nxt;
  logic                     out_valid_r;
  spq_pkg::status_t         status_r, status_nxt;
  spq_pkg::entry_t          head_r, head_nxt;

  spq_pkg::cell_ctrl_t      ctrl;
  spq_pkg::entry_t          cell_entry [D];
  logic [D-1:0]             cell_wants;
  logic [D-1:0]             cell_occ;

  logic                     accept;
  logic                     is_insert;
  logic                     prio_bad;
  logic                     full;
  logic                     empty;
  logic [CW+spq_pkg::OCC_W-1:0] occ_wide;

  // Accept while no result waits or the waiting one is taken now
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_insert     = (in_chan.req_type == spq_pkg::REQ_INSERT);
  assign prio_bad      = (in_chan.job_priority < spq_pkg::PRIO_MIN) ||
                         (in_chan.job_priority > spq_pkg::PRIO_MAX);
  assign full          = (count_r == CW'(D));
  assign empty         = (count_r == '0);

  // Broadcast command to the chain
  always_comb begin
    ctrl.insert        = accept && is_insert && !prio_bad && !full;
    ctrl.remove        = accept && !is_insert && !empty;
    ctrl.new_entry.id   = in_chan.job_id;
    ctrl.new_entry.prio = in_chan.job_priority;
  end

  // Build the chain; slot i is held when i is below the job count
  for (genvar i = 0; i < D; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_w;

    assign cell_occ[i] = (count_r > CW'(i));

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_w = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_w = cell_wants[i-1];
    end

    if (i == D - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ_self    (cell_occ[i]),
      .left_wants  (left_w),
      .left_entry  (left_e),
      .right_entry (right_e),
      .wants       (cell_wants[i]),
      .entry       (cell_entry[i])
    );
  end

  // Result and count for the accepted request
  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    head_nxt   = head_r;
    if (accept) begin
      head_nxt = '0;
      if (is_insert) begin
        if (prio_bad) begin
          status_nxt = spq_pkg::ST_BADPRIO;
        end else if (full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          status_nxt = spq_pkg::ST_OK;
          count_nxt  = count_r + CW'(1);
        end
      end else begin
        if (empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          status_nxt = spq_pkg::ST_OK;
          head_nxt   = cell_entry[0];
          count_nxt  = count_r - CW'(1);
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    head_r   <= head_nxt;
  end

  // Count only changes together with a new result, so it is the occupancy shown
  assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, count_r};

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.out_job_id   = head_r.id;
  assign out_chan.out_priority = head_r.prio;
  assign out_chan.occupancy    = occ_wide[spq_pkg::OCC_W-1:0];

endmodule

@@ rtl/spq_checker.sv @@
// Port-level checks for the stable priority queue, bound to the top level.
`timescale 1ns / 1ps

module spq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [spq_pkg::STAT_W-1:0]  status,
  input logic [spq_pkg::PRIO_W-1:0]  out_priority,
  input logic [spq_pkg::OCC_W-1:0]   occupancy
);

  // Every accepted request yields a result in the next cycle
  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A nonzero returned priority only comes with a successful remove
  a_prio_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_priority != '0) |->
      (status == spq_pkg::ST_OK) && (out_priority >= spq_pkg::PRIO_MIN) &&
      (out_priority <= spq_pkg::PRIO_MAX))
    else $error("bad priority on result");

  // Occupancy never exceeds the store size
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (spq_pkg::DEPTH > 31) || (int'(occupancy) <= spq_pkg::DEPTH))
    else $error("occupancy above depth");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .status       (out_chan.status),
  .out_priority (out_chan.out_priority),
  .occupancy    (out_chan.occupancy)
);
